// ----- rtl/core/tfn_pkg.sv -----
// Shared widths and types for the triangle face normal pipeline.
// No dependencies; used by tfn_unit and triangle_face_normal.
package tfn_pkg;

  localparam int UNIT_FRAC = 30;
  localparam int MAG_W     = 30;
  localparam int SQ_W      = 60;
  localparam int SUM_W     = 62;
  localparam int LEN_W     = 31;
  localparam int REM_W     = 34;
  localparam int NUM_W     = 61;
  localparam int Q_W       = 31;
  localparam int DR_W      = 32;
  localparam int OUT_W     = 32;
  localparam int CROSS_W   = 63;

  typedef struct packed {
    logic valid;
    logic zero;
  } unit_ctl_t;

endpackage

// ----- rtl/core/tfn_unit.sv -----
// Pipelined unit-length scaling of a signed 3-vector into signed Q1.30.
// Depends on tfn_pkg for widths and the control struct.
module tfn_unit #(
  parameter int IN_W = 33
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [IN_W-1:0]              vec_in  [3],
  output logic signed [tfn_pkg::OUT_W-1:0]    vec_out [3],
  output tfn_pkg::unit_ctl_t                  ctl_out
);

  localparam int NW = (IN_W > tfn_pkg::MAG_W) ? IN_W : tfn_pkg::MAG_W;
  localparam int NS = $clog2(NW);

  typedef struct packed {
    logic                  valid;
    logic [2:0][NW-1:0]    mag;
    logic [NW-1:0]         top;
    logic [2:0]            neg;
    logic                  zero;
  } nrm_t;

  typedef struct packed {
    logic                                  valid;
    logic [2:0][tfn_pkg::MAG_W-1:0]        m;
    logic [2:0][tfn_pkg::SQ_W-1:0]         sq;
    logic [2:0]                            neg;
    logic                                  zero;
  } sq_t;

  typedef struct packed {
    logic                                  valid;
    logic [2:0][tfn_pkg::MAG_W-1:0]        m;
    logic [2:0]                            neg;
    logic                                  zero;
    logic [tfn_pkg::SUM_W-1:0]             s;
    logic [tfn_pkg::REM_W-1:0]             rem;
    logic [tfn_pkg::LEN_W-1:0]             root;
  } rt_t;

  typedef struct packed {
    logic                                  valid;
    logic [2:0][tfn_pkg::NUM_W-1:0]        num;
    logic [tfn_pkg::LEN_W-1:0]             len;
    logic [2:0][tfn_pkg::DR_W-1:0]         r;
    logic [2:0][tfn_pkg::Q_W-1:0]          q;
    logic [2:0]                            neg;
    logic                                  zero;
  } dv_t;

  nrm_t nst [0:NS];
  nrm_t nst0_next;
  sq_t  sqs, sqs_next;
  rt_t  rts [0:tfn_pkg::LEN_W];
  rt_t  rts0_next;
  dv_t  dvs [0:tfn_pkg::Q_W];
  dv_t  dvs0_next;
  logic signed [tfn_pkg::OUT_W-1:0] res [3];
  logic signed [tfn_pkg::OUT_W-1:0] res_next [3];
  tfn_pkg::unit_ctl_t ctl, ctl_next;

  always_comb begin
    logic [IN_W-1:0] a;
    nst0_next.valid = in_valid;
    nst0_next.top   = '0;
    for (int i = 0; i < 3; i++) begin
      a = vec_in[i][IN_W-1] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
      nst0_next.neg[i] = vec_in[i][IN_W-1];
      nst0_next.mag[i] = NW'(a);
      if (NW'(a) > nst0_next.top) begin
        nst0_next.top = NW'(a);
      end
    end
    nst0_next.zero = (nst0_next.top == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nst[0].valid <= 1'b0;
    end else begin
      nst[0] <= nst0_next;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int S = 1 << (NS - 1 - k);
    nrm_t nxt;
    always_comb begin
      nxt = nst[k];
      if (nst[k].top[NW-1 -: S] == '0) begin
        nxt.top = nst[k].top << S;
        for (int i = 0; i < 3; i++) begin
          nxt.mag[i] = nst[k].mag[i] << S;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        nst[k+1].valid <= 1'b0;
      end else begin
        nst[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    sqs_next.valid = nst[NS].valid;
    sqs_next.neg   = nst[NS].neg;
    sqs_next.zero  = nst[NS].zero;
    for (int i = 0; i < 3; i++) begin
      sqs_next.m[i]  = nst[NS].mag[i][NW-1 -: tfn_pkg::MAG_W];
      sqs_next.sq[i] = {{(tfn_pkg::SQ_W-tfn_pkg::MAG_W){1'b0}}, sqs_next.m[i]} *
                       {{(tfn_pkg::SQ_W-tfn_pkg::MAG_W){1'b0}}, sqs_next.m[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sqs.valid <= 1'b0;
    end else begin
      sqs <= sqs_next;
    end
  end

  always_comb begin
    rts0_next.valid = sqs.valid;
    rts0_next.m     = sqs.m;
    rts0_next.neg   = sqs.neg;
    rts0_next.zero  = sqs.zero;
    rts0_next.s     = tfn_pkg::SUM_W'(sqs.sq[0]) + tfn_pkg::SUM_W'(sqs.sq[1]) +
                      tfn_pkg::SUM_W'(sqs.sq[2]);
    rts0_next.rem   = '0;
    rts0_next.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rts[0].valid <= 1'b0;
    end else begin
      rts[0] <= rts0_next;
    end
  end

  for (genvar j = 0; j < tfn_pkg::LEN_W; j++) begin : g_sqrt
    localparam int B = tfn_pkg::LEN_W - 1 - j;
    rt_t nxt;
    always_comb begin
      logic [tfn_pkg::REM_W-1:0] rsh;
      logic [tfn_pkg::REM_W-1:0] trial;
      nxt   = rts[j];
      rsh   = {rts[j].rem[tfn_pkg::REM_W-3:0], rts[j].s[2*B+1 -: 2]};
      trial = {{(tfn_pkg::REM_W-tfn_pkg::LEN_W-2){1'b0}}, rts[j].root, 2'b01};
      if (rsh >= trial) begin
        nxt.rem  = rsh - trial;
        nxt.root = {rts[j].root[tfn_pkg::LEN_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rsh;
        nxt.root = {rts[j].root[tfn_pkg::LEN_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rts[j+1].valid <= 1'b0;
      end else begin
        rts[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    dvs0_next.valid = rts[tfn_pkg::LEN_W].valid;
    dvs0_next.len   = rts[tfn_pkg::LEN_W].root;
    dvs0_next.neg   = rts[tfn_pkg::LEN_W].neg;
    dvs0_next.zero  = rts[tfn_pkg::LEN_W].zero;
    dvs0_next.q     = '0;
    for (int i = 0; i < 3; i++) begin
      dvs0_next.num[i] = (tfn_pkg::NUM_W'(rts[tfn_pkg::LEN_W].m[i]) << tfn_pkg::UNIT_FRAC) +
                         tfn_pkg::NUM_W'(rts[tfn_pkg::LEN_W].root >> 1);
      dvs0_next.r[i]   = tfn_pkg::DR_W'(dvs0_next.num[i] >> tfn_pkg::Q_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvs[0].valid <= 1'b0;
    end else begin
      dvs[0] <= dvs0_next;
    end
  end

  for (genvar j = 0; j < tfn_pkg::Q_W; j++) begin : g_div
    localparam int B = tfn_pkg::Q_W - 1 - j;
    dv_t nxt;
    always_comb begin
      logic [tfn_pkg::DR_W-1:0] rsh;
      logic [tfn_pkg::DR_W-1:0] d;
      nxt = dvs[j];
      d   = tfn_pkg::DR_W'(dvs[j].len);
      for (int i = 0; i < 3; i++) begin
        rsh = {dvs[j].r[i][tfn_pkg::DR_W-2:0], dvs[j].num[i][B]};
        if (rsh >= d) begin
          nxt.r[i]    = rsh - d;
          nxt.q[i][B] = 1'b1;
        end else begin
          nxt.r[i]    = rsh;
          nxt.q[i][B] = 1'b0;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvs[j+1].valid <= 1'b0;
      end else begin
        dvs[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    logic signed [tfn_pkg::OUT_W-1:0] qs;
    ctl_next.valid = dvs[tfn_pkg::Q_W].valid;
    ctl_next.zero  = dvs[tfn_pkg::Q_W].zero;
    for (int i = 0; i < 3; i++) begin
      qs = tfn_pkg::OUT_W'(dvs[tfn_pkg::Q_W].q[i]);
      if (dvs[tfn_pkg::Q_W].zero) begin
        res_next[i] = '0;
      end else if (dvs[tfn_pkg::Q_W].neg[i]) begin
        res_next[i] = -qs;
      end else begin
        res_next[i] = qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl <= ctl_next;
    end
    res <= res_next;
  end

  assign vec_out = res;
  assign ctl_out = ctl;

endmodule

// ----- rtl/core/triangle_face_normal.sv -----
// Edge registers feed two scaling units for the COORD_WIDTH+1 bit edges; product and
// cross-product registers then feed a third unit for the 63-bit cross product. Each
// scaling unit is built around a 31-stage square root and a 31-stage divider.
// Throughput is one transaction per cycle; busy stays low, results cannot stall.
// Synchronous reset clears all valid bits; no result appears until fresh input.
// Depends on tfn_pkg and tfn_unit.
module triangle_face_normal #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_WIDTH-1:0]        a_x,
  input  logic signed [COORD_WIDTH-1:0]        a_y,
  input  logic signed [COORD_WIDTH-1:0]        a_z,
  input  logic signed [COORD_WIDTH-1:0]        b_x,
  input  logic signed [COORD_WIDTH-1:0]        b_y,
  input  logic signed [COORD_WIDTH-1:0]        b_z,
  input  logic signed [COORD_WIDTH-1:0]        c_x,
  input  logic signed [COORD_WIDTH-1:0]        c_y,
  input  logic signed [COORD_WIDTH-1:0]        c_z,
  output logic                                 done,
  output logic signed [tfn_pkg::OUT_W-1:0]     normal_x,
  output logic signed [tfn_pkg::OUT_W-1:0]     normal_y,
  output logic signed [tfn_pkg::OUT_W-1:0]     normal_z,
  output logic                                 degenerate
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * tfn_pkg::OUT_W;

  logic                             edge_valid;
  logic signed [EW-1:0]             e1 [3];
  logic signed [EW-1:0]             e2 [3];
  logic signed [tfn_pkg::OUT_W-1:0] u1 [3];
  logic signed [tfn_pkg::OUT_W-1:0] u2 [3];
  tfn_pkg::unit_ctl_t               ctl1, ctl2, ctl3;
  logic                             prod_valid, prod_zero;
  logic signed [PW-1:0]             prod [6];
  logic                             cr_valid;
  logic signed [tfn_pkg::CROSS_W-1:0] cr [3];
  logic signed [tfn_pkg::CROSS_W-1:0] cr_next [3];
  logic signed [tfn_pkg::OUT_W-1:0] n [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_valid <= 1'b0;
    end else begin
      edge_valid <= start && !busy;
    end
    e1[0] <= EW'(c_x) - EW'(b_x);
    e1[1] <= EW'(c_y) - EW'(b_y);
    e1[2] <= EW'(c_z) - EW'(b_z);
    e2[0] <= EW'(c_x) - EW'(a_x);
    e2[1] <= EW'(c_y) - EW'(a_y);
    e2[2] <= EW'(c_z) - EW'(a_z);
  end

  tfn_unit #(.IN_W(EW)) u_edge1 (
    .clk(clk), .rst(rst), .in_valid(edge_valid), .vec_in(e1), .vec_out(u1), .ctl_out(ctl1)
  );

  tfn_unit #(.IN_W(EW)) u_edge2 (
    .clk(clk), .rst(rst), .in_valid(edge_valid), .vec_in(e2), .vec_out(u2), .ctl_out(ctl2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl1.valid;
    end
    prod_zero <= ctl1.zero || ctl2.zero;
    prod[0]   <= PW'(u1[1]) * PW'(u2[2]);
    prod[1]   <= PW'(u1[2]) * PW'(u2[1]);
    prod[2]   <= PW'(u1[2]) * PW'(u2[0]);
    prod[3]   <= PW'(u1[0]) * PW'(u2[2]);
    prod[4]   <= PW'(u1[0]) * PW'(u2[1]);
    prod[5]   <= PW'(u1[1]) * PW'(u2[0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (prod_zero) begin
        cr_next[i] = '0;
      end else begin
        cr_next[i] = tfn_pkg::CROSS_W'(prod[2*i] - prod[2*i+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_valid <= 1'b0;
    end else begin
      cr_valid <= prod_valid;
    end
    cr <= cr_next;
  end

  tfn_unit #(.IN_W(tfn_pkg::CROSS_W)) u_cross (
    .clk(clk), .rst(rst), .in_valid(cr_valid), .vec_in(cr), .vec_out(n), .ctl_out(ctl3)
  );

  assign done       = ctl3.valid;
  assign degenerate = ctl3.zero;
  assign normal_x   = n[0];
  assign normal_y   = n[1];
  assign normal_z   = n[2];

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("degenerate result with nonzero normal");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (normal_x != '0 || normal_y != '0 || normal_z != '0))
    else $error("regular result with zero normal");

  a_edge_align: assert property (@(posedge clk) disable iff (rst)
    ctl1.valid == ctl2.valid)
    else $error("edge scaling units out of step");

endmodule

// ----- tb/tb_triangle_face_normal.sv -----
// Self-checking testbench for triangle_face_normal: drives vertex triples, predicts the
// unit normal and degenerate flag in fixed point, and compares every done strobe.
// Depends on tfn_pkg and the triangle_face_normal RTL.
module tb_triangle_face_normal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 320;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    logic signed [tfn_pkg::OUT_W-1:0] nx;
    logic signed [tfn_pkg::OUT_W-1:0] ny;
    logic signed [tfn_pkg::OUT_W-1:0] nz;
    logic                             degen;
  } normal_t;

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  logic   done;
  logic signed [tfn_pkg::OUT_W-1:0] normal_x, normal_y, normal_z;
  logic   degenerate;

  normal_t normal_q[$];
  int      errors;
  int      idle_cycles;
  bit      allow_gaps;

  triangle_face_normal #(.COORD_WIDTH(CW)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned isqrt(input longint unsigned s);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit normalize(input longint v[3], output longint u[3]);
    longint unsigned mag[3];
    bit              neg[3];
    longint unsigned top;
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    int              p;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b0;
    end
    p = -1;
    while (top != 0) begin
      top = top >> 1;
      p++;
    end
    for (int i = 0; i < 3; i++) begin
      if (p > 29) mag[i] = mag[i] >> (p - 29);
      else mag[i] = mag[i] << (29 - p);
      sum += mag[i] * mag[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (len >> 1)) / len;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic normal_t face_normal(input coord_t p[9]);
    longint  e1[3], e2[3], u1[3], u2[3], cr[3], n[3];
    bit      ok;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(p[6+i]) - longint'(p[3+i]);
      e2[i] = longint'(p[6+i]) - longint'(p[i]);
    end
    ok = normalize(e1, u1);
    ok = normalize(e2, u2) && ok;
    if (ok) begin
      cr[0] = u1[1] * u2[2] - u1[2] * u2[1];
      cr[1] = u1[2] * u2[0] - u1[0] * u2[2];
      cr[2] = u1[0] * u2[1] - u1[1] * u2[0];
      ok = normalize(cr, n);
    end
    if (!ok) for (int i = 0; i < 3; i++) n[i] = 0;
    r.nx = n[0][31:0];
    r.ny = n[1][31:0];
    r.nz = n[2][31:0];
    r.degen = !ok;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Called at a rising edge; waits for the edge where the transaction is accepted, then may idle for a random gap.
  task automatic send_triangle(input coord_t p[9]);
    start <= 1'b1;
    a_x <= p[0]; a_y <= p[1]; a_z <= p[2];
    b_x <= p[3]; b_y <= p[4]; b_z <= p[5];
    c_x <= p[6]; c_y <= p[7]; c_z <= p[8];
    @(posedge clk);
    while (busy) @(posedge clk);
    normal_q.push_back(face_normal(p));
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      2: return coord_t'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic test_directed();
    coord_t p[9];
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_triangle(p);
    p = '{5, 6, 7, 1, 2, 3, 5, 6, 7};
    send_triangle(p);
    p = '{1, 2, 3, 5, 6, 7, 5, 6, 7};
    send_triangle(p);
    p = '{0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0};
    send_triangle(p);
    p = '{0, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000};
    send_triangle(p);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(p);
    p = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    send_triangle(p);
    p = '{-3, 7, 11, 3, -7, -11, 6, -14, -22};
    send_triangle(p);
    p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send_triangle(p);
    p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_triangle(p);
    p = '{32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0};
    send_triangle(p);
    p = '{32'sh8000_0000, 1, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0};
    send_triangle(p);
    p = '{32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 1, 0, 0, 0};
    send_triangle(p);
    p = '{-1, -1, -1, 1, 1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0};
    send_triangle(p);
    p = '{32'sh4000_0000, 32'sh4000_0001, 0, 32'sh8000_0000, 32'sh8000_0000, 0,
          0, 0, 1};
    send_triangle(p);
  endtask

  task automatic test_random(input int count);
    coord_t p[9];
    int     kind;
    int     mode;
    int     k;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) p[i] = rand_coord(mode == 3 ? $urandom_range(0, 3) : mode);
      case (kind)
        0: for (int i = 0; i < 3; i++) p[6+i] = p[i];
        1: for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
        2: begin
          k = $urandom_range(1, 4);
          for (int i = 0; i < 3; i++) begin
            p[i] = $signed($urandom_range(0, 4000)) - 2000;
            p[3+i] = $signed($urandom_range(0, 4000)) - 2000;
            p[6+i] = p[3+i] + k * (p[3+i] - p[i]);
          end
        end
        default: ;
      endcase
      if (n >= count - 300) allow_gaps = 1'b0;
      send_triangle(p);
    end
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    normal_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_triangle_face_normal failed");
        $finish;
      end
      if (done) begin
        if (normal_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = normal_q.pop_front();
          if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
          if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
          if (normal_z !== want.nz) report_mismatch("normal_z", normal_z, want.nz);
          if (degenerate !== want.degen)
            report_mismatch("degenerate", degenerate, want.degen);
        end
      end
    end
  end

  initial begin
    errors = 0;
    allow_gaps = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    allow_gaps = 1'b1;
    test_random(1900);
    while (normal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_triangle_face_normal passed");
    end else begin
      $display("tb_triangle_face_normal failed");
    end
    $finish;
  end
endmodule
